// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IPRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IPRC_ASSERT(lbl, prop, msg)
`define IPRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/iprc_pkg.sv =====
// Types and constants for the ICMP probe reply classifier.
package iprc_pkg;

    localparam int unsigned BUFFER_BYTES_INT = 1500;
    localparam int unsigned CNT_W = 11;
    localparam logic [CNT_W-1:0] BUFFER_BYTES = CNT_W'(BUFFER_BYTES_INT);

    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] ICMP_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] CODE_TTL_TRANSIT   = 8'd0;
    localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
    localparam logic [7:0] PROTO_UDP          = 8'd17;

    localparam logic [1:0] VERDICT_IGNORED   = 2'd0;
    localparam logic [1:0] VERDICT_ROUTER    = 2'd1;
    localparam logic [1:0] VERDICT_REACHED   = 2'd2;
    localparam logic [1:0] VERDICT_UNREACH   = 2'd3;

    localparam logic CFG_SOURCE_PORT    = 1'b0;
    localparam logic CFG_DEST_PORT_BASE = 1'b1;

    localparam logic [15:0] SOURCE_PORT_RESET    = 16'd32768;
    localparam logic [15:0] DEST_PORT_BASE_RESET = 16'd33434;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] probe_seq;
    } in_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] unreach_code;
    } out_t;

endpackage

// ===== rtl/iprc_parser.sv =====
// Header field capture by byte offset and verdict logic for one packet.
`include "assert_macros.svh"

module iprc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  iprc_pkg::in_t     item,
    input  logic [15:0]       source_port,
    input  logic [15:0]       dest_port_base,
    output iprc_pkg::out_t    result
);

    logic [iprc_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [5:0]  outer_hdr_len_reg, outer_hdr_len_next;
    logic [5:0]  inner_hdr_len_reg, inner_hdr_len_next;
    logic [7:0]  msg_type_reg, msg_type_next;
    logic [7:0]  msg_code_reg, msg_code_next;
    logic [7:0]  inner_proto_reg, inner_proto_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    logic [15:0] exp_port_reg, exp_port_next;

    logic                       in_buf;
    logic [iprc_pkg::CNT_W-1:0] pos;
    logic [iprc_pkg::CNT_W-1:0] h1;
    logic [iprc_pkg::CNT_W-1:0] udp;
    logic [iprc_pkg::CNT_W-1:0] n;
    logic                       type_ok;
    logic                       len_ok;
    logic                       ports_ok;

    assign in_buf = byte_count_reg < iprc_pkg::BUFFER_BYTES;
    assign pos    = byte_count_reg;

    always_comb
    begin
        outer_hdr_len_next = outer_hdr_len_reg;
        inner_hdr_len_next = inner_hdr_len_reg;
        msg_type_next      = msg_type_reg;
        msg_code_next      = msg_code_reg;
        inner_proto_next   = inner_proto_reg;
        src_port_next      = src_port_reg;
        dst_port_next      = dst_port_reg;
        exp_port_next      = exp_port_reg;
        h1                 = {5'd0, outer_hdr_len_reg};
        udp                = '0;
        if (in_buf && pos == '0)
        begin
            outer_hdr_len_next = {item.data_byte[3:0], 2'b00};
            exp_port_next      = dest_port_base + item.probe_seq;
        end
        h1 = {5'd0, outer_hdr_len_next};
        if (in_buf)
        begin
            if (pos == h1)
                msg_type_next = item.data_byte;
            if (pos == h1 + 11'd1)
                msg_code_next = item.data_byte;
            if (pos == h1 + 11'd8)
                inner_hdr_len_next = {item.data_byte[3:0], 2'b00};
            if (pos == h1 + 11'd17)
                inner_proto_next = item.data_byte;
        end
        udp = h1 + 11'd8 + {5'd0, inner_hdr_len_next};
        if (in_buf)
        begin
            if (pos == udp)
                src_port_next[15:8] = item.data_byte;
            if (pos == udp + 11'd1)
                src_port_next[7:0] = item.data_byte;
            if (pos == udp + 11'd2)
                dst_port_next[15:8] = item.data_byte;
            if (pos == udp + 11'd3)
                dst_port_next[7:0] = item.data_byte;
        end
    end

    assign n = in_buf ? byte_count_reg + 11'd1 : byte_count_reg;

    always_comb
    begin
        byte_count_next = n;
        if (item.last_byte)
            byte_count_next = '0;
    end

    assign type_ok  = (msg_type_next == iprc_pkg::ICMP_TIME_EXCEEDED &&
                       msg_code_next == iprc_pkg::CODE_TTL_TRANSIT) ||
                      msg_type_next == iprc_pkg::ICMP_DEST_UNREACH;
    assign len_ok   = n >= h1 + 11'd28 && n >= udp + 11'd4;
    assign ports_ok = inner_proto_next == iprc_pkg::PROTO_UDP &&
                      src_port_next == source_port &&
                      dst_port_next == exp_port_next;

    always_comb
    begin
        result.verdict      = iprc_pkg::VERDICT_IGNORED;
        result.unreach_code = '0;
        if (type_ok && len_ok && ports_ok)
        begin
            if (msg_type_next == iprc_pkg::ICMP_TIME_EXCEEDED)
                result.verdict = iprc_pkg::VERDICT_ROUTER;
            else if (msg_code_next == iprc_pkg::CODE_PORT_UNREACH)
                result.verdict = iprc_pkg::VERDICT_REACHED;
            else
            begin
                result.verdict      = iprc_pkg::VERDICT_UNREACH;
                result.unreach_code = msg_code_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            outer_hdr_len_reg <= '0;
            inner_hdr_len_reg <= '0;
            msg_type_reg      <= '0;
            msg_code_reg      <= '0;
            inner_proto_reg   <= '0;
            src_port_reg      <= '0;
            dst_port_reg      <= '0;
            exp_port_reg      <= '0;
        end
        else if (fire)
        begin
            byte_count_reg    <= byte_count_next;
            outer_hdr_len_reg <= outer_hdr_len_next;
            inner_hdr_len_reg <= inner_hdr_len_next;
            msg_type_reg      <= msg_type_next;
            msg_code_reg      <= msg_code_next;
            inner_proto_reg   <= inner_proto_next;
            src_port_reg      <= src_port_next;
            dst_port_reg      <= dst_port_next;
            exp_port_reg      <= exp_port_next;
        end
    end

    `IPRC_ASSERT(a_count_sat, byte_count_reg <= iprc_pkg::BUFFER_BYTES,
                 "byte count past buffer")
    `IPRC_ASSERT_NEXT(a_count_clr, fire && item.last_byte, byte_count_reg == '0,
                      "count not cleared")
    `IPRC_ASSERT_NEXT(a_count_inc, fire && !item.last_byte && in_buf,
                      byte_count_reg == $past(byte_count_reg) + 11'd1,
                      "count did not advance")

endmodule

// ===== rtl/icmp_probe_reply_classifier_core.sv =====
// Top level of the ICMP probe reply classifier: input stage, config, result stage.
//
// Usage: packet bytes enter on the in channel (in_valid / in_stall / in_item),
// one transaction per byte, with last_byte set on the final byte. probe_seq is
// sampled on the first byte of each packet. One result transaction (verdict and
// unreach_code) leaves on the res channel for each packet, after its last byte.
// Result path: a last byte goes through the input register, then field capture and
// matching into the result register; a stalled result can hold it in between.
// Throughput: one byte per clock, set by the single capture stage, but for stalls.
// Receiver stall: a stalled result holds in the result register; non-final
// bytes keep flowing, and a final byte waits in the input register until the
// result register frees, which then stalls the sender.
// Configuration: cfg_we writes cfg_data into the register named by cfg_index
// (0 source_port, 1 dest_port_base); write only while the block is idle.
// Reset: rst_n clears both stages, the byte counter and captured fields, and
// loads source_port 32768 and dest_port_base 33434.
`include "assert_macros.svh"

module icmp_probe_reply_classifier_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  iprc_pkg::in_t     in_item,
    output logic              res_valid,
    input  logic              res_stall,
    output iprc_pkg::out_t    res_item,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);

    logic              in_vld_reg, in_vld_next;
    iprc_pkg::in_t     in_data_reg;
    logic              out_vld_reg, out_vld_next;
    iprc_pkg::out_t    out_data_reg;
    logic [15:0]       src_port_reg;
    logic [15:0]       base_port_reg;
    logic              proc_fire;
    logic              res_load;
    iprc_pkg::out_t    result;

    assign proc_fire = in_vld_reg && !(in_data_reg.last_byte && out_vld_reg && res_stall);
    assign res_load  = proc_fire && in_data_reg.last_byte;
    assign in_stall  = in_vld_reg && !proc_fire;

    assign in_vld_next  = in_stall ? in_vld_reg : in_valid;
    assign out_vld_next = res_load ? 1'b1 : (out_vld_reg && res_stall);

    iprc_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (proc_fire),
        .item           (in_data_reg),
        .source_port    (src_port_reg),
        .dest_port_base (base_port_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= in_item;
        if (res_load)
            out_data_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_reg  <= iprc_pkg::SOURCE_PORT_RESET;
            base_port_reg <= iprc_pkg::DEST_PORT_BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iprc_pkg::CFG_SOURCE_PORT:    src_port_reg  <= cfg_data;
                iprc_pkg::CFG_DEST_PORT_BASE: base_port_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign res_valid = out_vld_reg;
    assign res_item  = out_data_reg;

    `IPRC_ASSERT(a_code_zero, !res_valid || res_item.verdict == iprc_pkg::VERDICT_UNREACH || res_item.unreach_code == '0, "code set without unreachable verdict")
    `IPRC_ASSERT(a_stall_full, !in_stall || in_vld_reg, "stall with empty input register")
    `IPRC_ASSERT_NEXT(a_res_load, res_load, res_valid, "result not presented after last byte")

endmodule

// ===== tb/iprc_reply_checker.sv =====
// Checker for the ICMP probe reply classifier: tracks fields, predicts and compares verdicts.
module iprc_reply_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  iprc_pkg::in_t  in_item,
    input  logic           res_valid,
    input  logic           res_stall,
    input  iprc_pkg::out_t res_item,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data,
    output int             mismatches,
    output int             waiting,
    output int             verdicts_checked,
    output int             probe_hits
);

    iprc_pkg::out_t verdict_q[$];
    logic [15:0]    src_port_cfg;
    logic [15:0]    base_cfg;
    logic [10:0]    offset;
    logic [5:0]     outer_len;
    logic [5:0]     inner_len;
    logic [7:0]     msg_type;
    logic [7:0]     msg_code;
    logic [7:0]     inner_proto;
    logic [15:0]    quoted_src;
    logic [15:0]    quoted_dst;
    logic [15:0]    probe_dst;
    int             errs;
    int             checked;
    int             hits;

    function automatic iprc_pkg::out_t judge_packet();
        iprc_pkg::out_t r;
        int             n;
        int             h;
        r = '0;
        n = offset;
        h = outer_len;
        if (n < h + 8)
            return r;
        if (!((msg_type == iprc_pkg::ICMP_TIME_EXCEEDED &&
               msg_code == iprc_pkg::CODE_TTL_TRANSIT) ||
              msg_type == iprc_pkg::ICMP_DEST_UNREACH))
            return r;
        if (n < h + 28 || n < h + 8 + inner_len + 4)
            return r;
        if (inner_proto != iprc_pkg::PROTO_UDP || quoted_src != src_port_cfg ||
            quoted_dst != probe_dst)
            return r;
        if (msg_type == iprc_pkg::ICMP_TIME_EXCEEDED)
            r.verdict = iprc_pkg::VERDICT_ROUTER;
        else if (msg_code == iprc_pkg::CODE_PORT_UNREACH)
            r.verdict = iprc_pkg::VERDICT_REACHED;
        else
        begin
            r.verdict = iprc_pkg::VERDICT_UNREACH;
            r.unreach_code = msg_code;
        end
        return r;
    endfunction

    // Fields latch by offset; with tiny header lengths one byte may land in several.
    task automatic take_byte(input iprc_pkg::in_t beat);
        int         pos;
        int         h;
        int         u;
        logic [7:0] b;
        pos = offset;
        b = beat.data_byte;
        if (offset < iprc_pkg::BUFFER_BYTES)
        begin
            if (pos == 0)
                outer_len = {b[3:0], 2'b00};
            h = outer_len;
            if (pos == h)
                msg_type = b;
            if (pos == h + 1)
                msg_code = b;
            if (pos == h + 8)
                inner_len = {b[3:0], 2'b00};
            if (pos == h + 17)
                inner_proto = b;
            u = h + 8 + inner_len;
            if (pos == u)
                quoted_src[15:8] = b;
            if (pos == u + 1)
                quoted_src[7:0] = b;
            if (pos == u + 2)
                quoted_dst[15:8] = b;
            if (pos == u + 3)
                quoted_dst[7:0] = b;
            if (pos == 0)
                probe_dst = base_cfg + beat.probe_seq;
            offset = offset + 1'b1;
        end
        if (beat.last_byte)
        begin
            verdict_q.push_back(judge_packet());
            offset = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        iprc_pkg::out_t got;
        iprc_pkg::out_t want;
        if (!rst_n)
        begin
            verdict_q.delete();
            src_port_cfg = iprc_pkg::SOURCE_PORT_RESET;
            base_cfg = iprc_pkg::DEST_PORT_BASE_RESET;
            offset = '0;
            outer_len = '0;
            inner_len = '0;
            msg_type = '0;
            msg_code = '0;
            inner_proto = '0;
            quoted_src = '0;
            quoted_dst = '0;
            probe_dst = '0;
            errs = 0;
            checked = 0;
            hits = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == iprc_pkg::CFG_SOURCE_PORT)
                    src_port_cfg = cfg_data;
                else
                    base_cfg = cfg_data;
            end
            if (in_valid && !in_stall)
                take_byte(in_item);
            if (res_valid && !res_stall)
            begin
                got = res_item;
                checked++;
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected transaction: verdict %0d unreach_code %0d",
                           got.verdict, got.unreach_code);
                    errs++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                        errs++;
                    end
                    if (got.unreach_code !== want.unreach_code)
                    begin
                        $error("unreach_code: expected %0d, got %0d",
                               want.unreach_code, got.unreach_code);
                        errs++;
                    end
                    if (want.verdict != iprc_pkg::VERDICT_IGNORED)
                        hits++;
                end
            end
        end
        mismatches <= errs;
        waiting <= verdict_q.size();
        verdicts_checked <= checked;
        probe_hits <= hits;
    end

endmodule

// ===== tb/icmp_probe_reply_classifier_core_test.sv =====
// Testbench top for the ICMP probe reply classifier: clock, reset, packet stimulus and verdict.
module icmp_probe_reply_classifier_core_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int MIX_BYTES   = 150;

    logic           clk;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    iprc_pkg::in_t  in_item = '0;
    logic           res_valid;
    logic           res_stall = 1'b0;
    iprc_pkg::out_t res_item;
    logic           cfg_we = 1'b0;
    logic           cfg_index = iprc_pkg::CFG_SOURCE_PORT;
    logic [15:0]    cfg_data = '0;
    logic           hold_off = 1'b0;
    int             mismatches;
    int             waiting;
    int             verdicts_checked;
    int             probe_hits;

    logic [7:0]     pkt[$];
    logic [15:0]    cur_src = iprc_pkg::SOURCE_PORT_RESET;
    logic [15:0]    cur_base = iprc_pkg::DEST_PORT_BASE_RESET;
    int             burst_left = 0;
    int             bytes_sent = 0;
    int             packets_sent = 0;
    int             settings_used = 1;

    icmp_probe_reply_classifier_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iprc_reply_checker verdict_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .res_item         (res_item),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .waiting          (waiting),
        .verdicts_checked (verdicts_checked),
        .probe_hits       (probe_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: stall modes change every span; one long hold-off on request.
    initial
    begin : receiver
        int mode;
        int span;
        int k;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off && !held)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (k = 0; k < span; k++)
            begin
                if (hold_off && !held)
                    break;
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 99) < 30);
                    2: res_stall <= ($urandom_range(0, 99) < 70);
                    default: res_stall <= (k % 3 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic make_reply(input int ihl, input int iihl, input logic [7:0] typ,
                              input logic [7:0] code, input logic [7:0] proto,
                              input logic [15:0] sport, input logic [15:0] dport,
                              input int extra);
        int h;
        int u;
        int len;
        int k;
        h = ihl * 4;
        u = h + 8 + iihl * 4;
        len = (u + 4 > h + 28) ? u + 4 : h + 28;
        len += extra;
        pkt.delete();
        for (k = 0; k < len; k++)
            pkt.push_back(8'($urandom));
        pkt[0] = {4'h4, 4'(ihl)};
        pkt[h] = typ;
        pkt[h + 1] = code;
        pkt[h + 8] = {4'h4, 4'(iihl)};
        pkt[h + 17] = proto;
        pkt[u] = sport[15:8];
        pkt[u + 1] = sport[7:0];
        pkt[u + 2] = dport[15:8];
        pkt[u + 3] = dport[7:0];
    endtask

    task automatic make_noise(input int len);
        int k;
        pkt.delete();
        for (k = 0; k < len; k++)
            pkt.push_back(8'($urandom));
    endtask

    task automatic trim_packet(input int keep);
        while (pkt.size() > keep)
            void'(pkt.pop_back());
    endtask

    task automatic send_packet(input logic [15:0] seq);
        int            k;
        iprc_pkg::in_t beat;
        for (k = 0; k < pkt.size(); k++)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                         : $urandom_range(1, 30);
            end
            burst_left--;
            beat.data_byte = pkt[k];
            beat.last_byte = (k == pkt.size() - 1);
            beat.probe_seq = (k == 0) ? seq : 16'($urandom);
            in_item <= beat;
            in_valid <= 1'b1;
            do
                @(posedge clk);
            while (in_stall);
            bytes_sent++;
        end
        packets_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] sport, input logic [15:0] base);
        cfg_we <= 1'b1;
        cfg_index <= iprc_pkg::CFG_SOURCE_PORT;
        cfg_data <= sport;
        @(posedge clk);
        cfg_index <= iprc_pkg::CFG_DEST_PORT_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_src = sport;
        cur_base = base;
        settings_used++;
    endtask

    task automatic random_packet();
        int          kind;
        int          oihl;
        int          iihl;
        logic [15:0] seq;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  typ;
        logic [7:0]  code;
        logic [7:0]  proto;
        seq = 16'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            oihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
            iihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    typ = iprc_pkg::ICMP_TIME_EXCEEDED;
                    code = iprc_pkg::CODE_TTL_TRANSIT;
                end
                3, 4:
                begin
                    typ = iprc_pkg::ICMP_DEST_UNREACH;
                    code = iprc_pkg::CODE_PORT_UNREACH;
                end
                5, 6:
                begin
                    typ = iprc_pkg::ICMP_DEST_UNREACH;
                    code = 8'($urandom);
                end
                7:
                begin
                    typ = iprc_pkg::ICMP_TIME_EXCEEDED;
                    code = 8'($urandom_range(1, 255));
                end
                default:
                begin
                    typ = 8'($urandom);
                    code = 8'($urandom);
                end
            endcase
            proto = iprc_pkg::PROTO_UDP;
            sport = cur_src;
            dport = cur_base + seq;
            case ($urandom_range(0, 9))
                0: proto = 8'($urandom);
                1: sport = sport ^ 16'($urandom_range(1, 65535));
                2: dport = dport ^ 16'($urandom_range(1, 65535));
                default: ;
            endcase
            make_reply(oihl, iihl, typ, code, proto, sport, dport, $urandom_range(0, 12));
            if ($urandom_range(0, 6) == 0)
                trim_packet($urandom_range(1, pkt.size()));
        end
        else if (kind < 90)
            make_noise($urandom_range(1, 48));
        else
            make_noise($urandom_range(1, 4));
        send_packet(seq);
    endtask

    task automatic run_mix(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            random_packet();
    endtask

    initial
    begin : stimulus
        logic [15:0] seq;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets under the reset register values.
        make_reply(5, 5, iprc_pkg::ICMP_TIME_EXCEEDED, iprc_pkg::CODE_TTL_TRANSIT,
                   iprc_pkg::PROTO_UDP, cur_src, cur_base, 0);
        send_packet(16'h0000);
        seq = 16'hFFFF;
        make_reply(5, 5, iprc_pkg::ICMP_DEST_UNREACH, iprc_pkg::CODE_PORT_UNREACH,
                   iprc_pkg::PROTO_UDP, cur_src, cur_base + seq, 0);
        send_packet(seq);
        seq = 16'($urandom);
        make_reply(5, 5, iprc_pkg::ICMP_DEST_UNREACH, 8'hFF, iprc_pkg::PROTO_UDP, cur_src,
                   cur_base + seq, 2);
        send_packet(seq);
        seq = 16'($urandom);
        make_reply(5, 5, iprc_pkg::ICMP_DEST_UNREACH, 8'h00, iprc_pkg::PROTO_UDP, cur_src,
                   cur_base + seq, 0);
        send_packet(seq);
        // Tiny header lengths: ports overlap the inner length byte, or type overlaps byte 0.
        seq = 16'($urandom);
        make_reply(1, 0, iprc_pkg::ICMP_TIME_EXCEEDED, iprc_pkg::CODE_TTL_TRANSIT,
                   iprc_pkg::PROTO_UDP, cur_src, cur_base + seq, 0);
        send_packet(seq);
        seq = 16'($urandom);
        make_reply(0, 5, iprc_pkg::ICMP_DEST_UNREACH, iprc_pkg::CODE_PORT_UNREACH,
                   iprc_pkg::PROTO_UDP, cur_src, cur_base + seq, 0);
        send_packet(seq);
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet(16'hFFFF);
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet(16'h0000);
        seq = 16'($urandom);
        make_reply(5, 5, iprc_pkg::ICMP_TIME_EXCEEDED, 8'h01, iprc_pkg::PROTO_UDP, cur_src,
                   cur_base + seq, 0);
        send_packet(seq);
        seq = 16'($urandom);
        make_reply(15, 15, iprc_pkg::ICMP_TIME_EXCEEDED, iprc_pkg::CODE_TTL_TRANSIT,
                   iprc_pkg::PROTO_UDP, cur_src, cur_base + seq, 3);
        send_packet(seq);
        seq = 16'($urandom);
        make_reply(5, 5, iprc_pkg::ICMP_DEST_UNREACH, iprc_pkg::CODE_PORT_UNREACH, 8'd6,
                   cur_src, cur_base + seq, 0);
        send_packet(seq);
        // One byte short of a complete quoted header.
        seq = 16'($urandom);
        make_reply(5, 5, iprc_pkg::ICMP_TIME_EXCEEDED, iprc_pkg::CODE_TTL_TRANSIT,
                   iprc_pkg::PROTO_UDP, cur_src, cur_base + seq, 0);
        trim_packet(47);
        send_packet(seq);

        settle();
        set_config(16'hFFFF, 16'h0000);
        run_mix(MIX_BYTES);
        settle();
        set_config(16'h8000, 16'hFFFF);
        // Short packets while the receiver holds off fill both stages.
        hold_off <= 1'b1;
        repeat (3)
        begin
            make_noise(1);
            send_packet(16'($urandom));
        end
        run_mix(MIX_BYTES);
        settle();
        set_config(16'($urandom_range(32768, 65535)), 16'($urandom));
        run_mix(MIX_BYTES);
        settle();
        set_config(16'hFFFF, 16'hFFFF);
        run_mix(MIX_BYTES);
        settle();
        set_config(16'h8000, 16'h0000);
        run_mix(MIX_BYTES);
        settle();
        set_config(16'($urandom_range(32768, 65535)), 16'($urandom));
        run_mix(MIX_BYTES);

        settle();
        repeat (4) @(posedge clk);
        $display("Sent %0d packets, %0d bytes, under %0d port settings with one long hold.",
                 packets_sent, bytes_sent, settings_used);
        $display("Compared %0d verdict transactions, %0d of them probe matches.",
                 verdicts_checked, probe_hits);
        if (mismatches == 0 && waiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
